>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the controller. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/mbrts_pkg.sv
`timescale 1ns / 1ps

package mbrts_pkg;

    // Request kinds carried on tuser
    localparam logic [2:0] MODE_RD_COIL = 3'd0;
    localparam logic [2:0] MODE_RD_REG  = 3'd1;
    localparam logic [2:0] MODE_WR_COIL = 3'd2;
    localparam logic [2:0] MODE_WR_REG  = 3'd3;
    localparam logic [2:0] MODE_EL_COIL = 3'd4;
    localparam logic [2:0] MODE_EL_REG  = 3'd5;

    // Quantity limits of the protocol
    localparam logic [10:0] READ_COIL_MAX  = 11'd2000;
    localparam logic [10:0] READ_REG_MAX   = 11'd125;
    localparam logic [10:0] WRITE_COIL_MAX = 11'd1968;
    localparam logic [10:0] WRITE_REG_MAX  = 11'd123;

    // Frame sizes
    localparam logic [8:0] HEADER_BYTES = 9'd3;
    localparam logic [8:0] FRAME_EXTRA  = 9'd6;
    localparam logic [8:0] ACK_FRAME    = 9'd12;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ISSUE,
        ST_CAPTURE,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic rd_capture;
        logic rd_next;
        logic chunk_clear;
        logic do_write;
        logic emit_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic is_write;
        logic zero_qty;
        logic ack_needed;
        logic chunk_end;
        logic final_elem;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/mbrts_ram.sv
`timescale 1ns / 1ps

module mbrts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, then registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mbrts_datapath.sv
`timescale 1ns / 1ps

module mbrts_datapath #(
    parameter int REG_COUNT  = 128,
    parameter int COIL_COUNT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mbrts_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [2:0]                      s_tuser,
    input  logic                            s_tlast,
    input  mbrts_pkg::cmd_t                 cmd,
    output mbrts_pkg::status_t              sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbrts_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int REG_AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int COIL_AW = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
    localparam int CLR_MAX = (REG_COUNT > COIL_COUNT) ? REG_COUNT : COIL_COUNT;
    localparam int CLR_W   = (CLR_MAX > 1) ? $clog2(CLR_MAX) : 1;

    // Request registers
    logic [2:0]       mode_reg;
    logic [15:0]      start_reg;
    logic [10:0]      qty_reg;
    logic [15:0]      value_reg;
    logic             last_reg;
    logic [10:0]      n_reg;
    logic [63:0]      chunk_reg;
    logic [CLR_W-1:0] clr_reg;
    logic [CLR_W-1:0] clr_next;

    // Output register
    logic        m_valid_reg;
    logic [7:0]  m_bytes_reg;
    logic [8:0]  m_frame_reg;
    logic [63:0] m_chunk_reg;
    logic        m_last_reg;

    logic [10:0] in_qty;
    logic [10:0] qty_clamped;
    logic [2:0]  in_mode;
    logic        in_single;

    logic [16:0] addr;
    logic        reg_in_range;
    logic        coil_in_range;
    logic        clr_in_reg;
    logic        clr_in_coil;
    logic        write_ok;
    logic        is_reg_write;
    logic        is_coil_write;
    logic        is_single;
    logic [11:0] n_plus;
    logic [11:0] coil_sum;
    logic [7:0]  bytes;
    logic [8:0]  frame;

    logic              reg_we;
    logic [REG_AW-1:0] reg_waddr;
    logic [15:0]       reg_wdata;
    logic [15:0]       reg_rdata;
    logic              coil_we;
    logic [COIL_AW-1:0] coil_waddr;
    logic              coil_wdata;
    logic              coil_rdata;

    // Decode and clamp the incoming request
    assign in_mode = s_tuser;
    assign in_qty  = s_tdata[26:16];
    assign in_single = (in_mode == mbrts_pkg::MODE_WR_COIL) ||
                       (in_mode == mbrts_pkg::MODE_WR_REG);

    always_comb begin
        qty_clamped = in_qty;
        case (in_mode)
            mbrts_pkg::MODE_RD_COIL: begin
                if (in_qty > mbrts_pkg::READ_COIL_MAX) qty_clamped = mbrts_pkg::READ_COIL_MAX;
            end
            mbrts_pkg::MODE_RD_REG: begin
                if (in_qty > mbrts_pkg::READ_REG_MAX) qty_clamped = mbrts_pkg::READ_REG_MAX;
            end
            mbrts_pkg::MODE_EL_COIL: begin
                if (in_qty > mbrts_pkg::WRITE_COIL_MAX) qty_clamped = mbrts_pkg::WRITE_COIL_MAX;
            end
            mbrts_pkg::MODE_EL_REG: begin
                if (in_qty > mbrts_pkg::WRITE_REG_MAX) qty_clamped = mbrts_pkg::WRITE_REG_MAX;
            end
            default: qty_clamped = in_qty;
        endcase
    end

    // Element address, shared by reads and writes
    assign addr          = 17'(start_reg) + 17'(n_reg);
    assign reg_in_range  = addr < 17'(REG_COUNT);
    assign coil_in_range = addr < 17'(COIL_COUNT);
    assign clr_in_reg    = 17'(clr_reg) < 17'(REG_COUNT);
    assign clr_in_coil   = 17'(clr_reg) < 17'(COIL_COUNT);
    assign clr_next      = clr_reg + CLR_W'(1);

    assign is_single     = (mode_reg == mbrts_pkg::MODE_WR_COIL) ||
                           (mode_reg == mbrts_pkg::MODE_WR_REG);
    assign is_reg_write  = (mode_reg == mbrts_pkg::MODE_WR_REG) ||
                           (mode_reg == mbrts_pkg::MODE_EL_REG);
    assign is_coil_write = (mode_reg == mbrts_pkg::MODE_WR_COIL) ||
                           (mode_reg == mbrts_pkg::MODE_EL_COIL);
    assign write_ok      = is_single || (n_reg < qty_reg);

    // Store write ports: clearing pass or request write
    assign reg_we     = cmd.clr_step ? clr_in_reg
                                     : (cmd.do_write && is_reg_write && write_ok && reg_in_range);
    assign reg_waddr  = cmd.clr_step ? clr_reg[REG_AW-1:0] : addr[REG_AW-1:0];
    assign reg_wdata  = cmd.clr_step ? 16'd0 : value_reg;
    assign coil_we    = cmd.clr_step ? clr_in_coil
                                     : (cmd.do_write && is_coil_write && write_ok && coil_in_range);
    assign coil_waddr = cmd.clr_step ? clr_reg[COIL_AW-1:0] : addr[COIL_AW-1:0];
    assign coil_wdata = cmd.clr_step ? 1'b0 : (|value_reg);

    mbrts_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_reg_ram (
        .clk   (aclk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (addr[REG_AW-1:0]),
        .rdata (reg_rdata)
    );

    mbrts_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_coil_ram (
        .clk   (aclk),
        .we    (coil_we),
        .waddr (coil_waddr),
        .wdata (coil_wdata),
        .raddr (addr[COIL_AW-1:0]),
        .rdata (coil_rdata)
    );

    // Response sizes
    assign coil_sum = 12'(qty_reg) + 12'd7;
    assign bytes = (mode_reg == mbrts_pkg::MODE_RD_COIL) ? coil_sum[10:3]
                                                         : {qty_reg[6:0], 1'b0};
    assign frame = 9'(bytes) + mbrts_pkg::HEADER_BYTES + mbrts_pkg::FRAME_EXTRA;
    assign n_plus = 12'(n_reg) + 12'd1;

    // Status toward the controller
    always_comb begin
        sts.clr_done   = clr_reg == CLR_W'(CLR_MAX - 1);
        sts.is_read    = (mode_reg == mbrts_pkg::MODE_RD_COIL) ||
                         (mode_reg == mbrts_pkg::MODE_RD_REG);
        sts.zero_qty   = qty_reg == 11'd0;
        sts.is_write   = 1'b0;
        sts.ack_needed = 1'b0;
        case (mode_reg) inside
            mbrts_pkg::MODE_WR_COIL, mbrts_pkg::MODE_WR_REG: begin
                sts.is_write   = 1'b1;
                sts.ack_needed = 1'b1;
            end
            mbrts_pkg::MODE_EL_COIL, mbrts_pkg::MODE_EL_REG: begin
                sts.is_write   = 1'b1;
                sts.ack_needed = last_reg;
            end
            default: begin
                sts.is_write   = 1'b0;
                sts.ack_needed = 1'b0;
            end
        endcase
        sts.final_elem = !sts.is_read || sts.zero_qty || (n_plus == 12'(qty_reg));
        sts.chunk_end  = sts.final_elem ||
                         ((mode_reg == mbrts_pkg::MODE_RD_COIL) ? (n_reg[5:0] == 6'd63)
                                                                : (n_reg[1:0] == 2'd3));
        sts.out_free   = !m_valid_reg || m_tready;
    end

    // Clear counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step && !sts.clr_done) begin
            clr_reg <= clr_next;
        end
    end

    // Capture the request, walk elements, build chunks
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            mode_reg  <= in_mode;
            start_reg <= s_tdata[15:0];
            qty_reg   <= qty_clamped;
            n_reg     <= (in_single || in_mode == mbrts_pkg::MODE_RD_COIL ||
                          in_mode == mbrts_pkg::MODE_RD_REG) ? 11'd0 : s_tdata[37:27];
            value_reg <= s_tdata[53:38];
            last_reg  <= s_tlast;
            chunk_reg <= 64'd0;
        end else begin
            if (cmd.rd_capture) begin
                if (mode_reg == mbrts_pkg::MODE_RD_COIL) begin
                    chunk_reg[n_reg[5:0]] <= coil_in_range & coil_rdata;
                end else begin
                    case (n_reg[1:0])
                        2'd0: chunk_reg[63:48] <= reg_in_range ? reg_rdata : 16'd0;
                        2'd1: chunk_reg[47:32] <= reg_in_range ? reg_rdata : 16'd0;
                        2'd2: chunk_reg[31:16] <= reg_in_range ? reg_rdata : 16'd0;
                        default: chunk_reg[15:0] <= reg_in_range ? reg_rdata : 16'd0;
                    endcase
                end
            end
            if (cmd.chunk_clear) begin
                chunk_reg <= 64'd0;
            end
            if (cmd.rd_next) begin
                n_reg <= n_reg + 11'd1;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            if (sts.is_read) begin
                m_bytes_reg <= bytes;
                m_frame_reg <= frame;
                m_chunk_reg <= chunk_reg;
                m_last_reg  <= sts.final_elem;
            end else begin
                m_bytes_reg <= 8'd0;
                m_frame_reg <= mbrts_pkg::ACK_FRAME;
                m_chunk_reg <= 64'd0;
                m_last_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_chunk_reg, m_frame_reg, m_bytes_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> hw/rtl/mbrts_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbrts_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output mbrts_pkg::cmd_t    cmd,
    input  mbrts_pkg::status_t sts
);

    mbrts_pkg::state_t state_reg;
    mbrts_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbrts_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbrts_pkg::ST_CLEAR: begin
                if (sts.clr_done) state_next = mbrts_pkg::ST_IDLE;
            end
            mbrts_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = mbrts_pkg::ST_DECODE;
            end
            mbrts_pkg::ST_DECODE: begin
                if (sts.is_read) begin
                    state_next = sts.zero_qty ? mbrts_pkg::ST_EMIT : mbrts_pkg::ST_ISSUE;
                end else if (sts.is_write) begin
                    state_next = mbrts_pkg::ST_WRITE;
                end else begin
                    state_next = mbrts_pkg::ST_IDLE;
                end
            end
            mbrts_pkg::ST_ISSUE: begin
                state_next = mbrts_pkg::ST_CAPTURE;
            end
            mbrts_pkg::ST_CAPTURE: begin
                state_next = sts.chunk_end ? mbrts_pkg::ST_EMIT : mbrts_pkg::ST_ISSUE;
            end
            mbrts_pkg::ST_WRITE: begin
                state_next = sts.ack_needed ? mbrts_pkg::ST_EMIT : mbrts_pkg::ST_IDLE;
            end
            mbrts_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = sts.final_elem ? mbrts_pkg::ST_IDLE : mbrts_pkg::ST_ISSUE;
                end
            end
            default: state_next = mbrts_pkg::ST_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mbrts_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
            mbrts_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            mbrts_pkg::ST_DECODE: cmd = '0;
            mbrts_pkg::ST_ISSUE:  cmd = '0;
            mbrts_pkg::ST_CAPTURE: begin
                cmd.rd_capture = 1'b1;
                cmd.rd_next    = !sts.chunk_end;
            end
            mbrts_pkg::ST_WRITE: cmd.do_write = 1'b1;
            mbrts_pkg::ST_EMIT: begin
                cmd.emit_load   = sts.out_free;
                cmd.rd_next     = sts.out_free && !sts.final_elem;
                cmd.chunk_clear = sts.out_free && !sts.final_elem;
            end
            default: cmd = '0;
        endcase
    end

    // A result is loaded only into a free output register
    `ASSERT_CLK(a_emit_free, aclk, aresetn, cmd.emit_load |-> sts.out_free)
    // The clearing pass runs once after reset
    `ASSERT_CLK(a_clear_once, aclk, aresetn,
        (state_reg != mbrts_pkg::ST_CLEAR) |=> (state_reg != mbrts_pkg::ST_CLEAR))
    // A captured element either continues the walk or closes a chunk
    `ASSERT_CLK(a_capture_next, aclk, aresetn,
        (state_reg == mbrts_pkg::ST_CAPTURE) |=>
        (state_reg == mbrts_pkg::ST_ISSUE || state_reg == mbrts_pkg::ST_EMIT))

endmodule

>>> hw/rtl/modbus_register_table_server.sv
`timescale 1ns / 1ps

// Modbus register table server. Each request carries a decoded Modbus
// request: read coils, read registers, write a single coil or register,
// or one element of a multiple write. Reads answer with one or more
// results, each holding the byte count, the frame length and a 64-bit
// chunk (four registers with the first in the top bits, or 64 coils with
// the first in bit 0); writes answer with one acknowledgement, elements
// of a multiple write only on the element marked last. After reset the
// block runs a clearing pass over both stores, during which s_tready
// stays low. Each store is a RAM with one write port and one registered
// read port, and the walk reads each element in an ISSUE state followed
// by a CAPTURE state: a read of Q elements answers with C results, where
// C is ceil(Q/64) for coils or ceil(Q/4) for registers, at least one.
// A write passes through DECODE and WRITE, and through EMIT when it
// answers. Each result leaves from EMIT, which waits on m_tready while
// the output register is full; a new request is taken only in IDLE.

module modbus_register_table_server #(
    parameter int REG_COUNT  = 128,
    parameter int COIL_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_address[15:0], quantity[26:16], element_index[37:27],
    // write_value[53:38], zero pad[55:54]
    input  logic [55:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    // last_element
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_count[7:0], frame_bytes[16:8], data_chunk[80:17], zero pad[87:81]
    output logic [87:0] m_tdata,
    // last_result
    output logic        m_tlast
);

    mbrts_pkg::cmd_t    cmd;
    mbrts_pkg::status_t sts;

    mbrts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mbrts_datapath #(
        .REG_COUNT  (REG_COUNT),
        .COIL_COUNT (COIL_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/modbus_register_table_server_tb.sv
`timescale 1ns / 1ps

module modbus_register_table_server_tb;

    localparam int REG_DEPTH   = 128;
    localparam int COIL_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_REQS = 320;

    // Modes the block must ignore
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] start;
        logic [10:0] qty;
        logic [10:0] idx;
        logic [15:0] value;
        logic        last;
    } mb_req_t;

    typedef struct {
        logic [7:0]  byte_count;
        logic [8:0]  frame_bytes;
        logic [63:0] data_chunk;
        logic        last;
    } mb_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tlast;

    // Shadow copies of both stores
    logic [15:0] hold_mem [REG_DEPTH];
    logic        coil_mem [COIL_DEPTH];

    mb_resp_t    pending_resp [$];
    int          error_count = 0;
    int          reqs_sent = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    bit          hold_off_req = 1'b0;

    modbus_register_table_server dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic mb_req_t make_req(input logic [2:0] mode, input int unsigned start,
                                         input int unsigned qty, input int unsigned idx,
                                         input int unsigned value, input bit last);
        mb_req_t r;
        r.mode  = mode;
        r.start = start[15:0];
        r.qty   = qty[10:0];
        r.idx   = idx[10:0];
        r.value = value[15:0];
        r.last  = last;
        return r;
    endfunction

    function automatic void push_ack();
        mb_resp_t rsp;
        rsp.byte_count  = '0;
        rsp.frame_bytes = mbrts_pkg::ACK_FRAME;
        rsp.data_chunk  = '0;
        rsp.last        = 1'b1;
        pending_resp.push_back(rsp);
    endfunction

    // Apply one accepted request to the shadow stores and queue its responses
    function automatic void serve_request(input mb_req_t r);
        mb_resp_t    rsp;
        int unsigned q, nbytes, nchunks, c, j, n, addr;
        logic [63:0] d;
        case (r.mode) inside
            mbrts_pkg::MODE_RD_COIL, mbrts_pkg::MODE_RD_REG: begin
                if (r.mode == mbrts_pkg::MODE_RD_COIL) begin
                    q = (r.qty > mbrts_pkg::READ_COIL_MAX) ? mbrts_pkg::READ_COIL_MAX : r.qty;
                    nbytes = (q + 7) / 8;
                    nchunks = (q + 63) / 64;
                end else begin
                    q = (r.qty > mbrts_pkg::READ_REG_MAX) ? mbrts_pkg::READ_REG_MAX : r.qty;
                    nbytes = q * 2;
                    nchunks = (q + 3) / 4;
                end
                if (nchunks == 0) nchunks = 1;
                for (c = 0; c < nchunks; c++) begin
                    d = '0;
                    if (r.mode == mbrts_pkg::MODE_RD_COIL) begin
                        for (j = 0; j < 64; j++) begin
                            n = c * 64 + j;
                            addr = r.start + n;
                            if (n < q && addr < COIL_DEPTH && coil_mem[addr]) d[j] = 1'b1;
                        end
                    end else begin
                        for (j = 0; j < 4; j++) begin
                            n = c * 4 + j;
                            addr = r.start + n;
                            if (n < q && addr < REG_DEPTH) d[63 - 16 * j -: 16] = hold_mem[addr];
                        end
                    end
                    rsp.byte_count  = 8'(nbytes);
                    rsp.frame_bytes = 9'(nbytes + mbrts_pkg::HEADER_BYTES
                                         + mbrts_pkg::FRAME_EXTRA);
                    rsp.data_chunk  = d;
                    rsp.last        = (c + 1 == nchunks);
                    pending_resp.push_back(rsp);
                end
            end
            mbrts_pkg::MODE_WR_COIL: begin
                if (r.start < COIL_DEPTH) coil_mem[r.start] = (r.value != 0);
                push_ack();
            end
            mbrts_pkg::MODE_WR_REG: begin
                if (r.start < REG_DEPTH) hold_mem[r.start] = r.value;
                push_ack();
            end
            mbrts_pkg::MODE_EL_COIL: begin
                q = (r.qty > mbrts_pkg::WRITE_COIL_MAX) ? mbrts_pkg::WRITE_COIL_MAX : r.qty;
                addr = r.start + r.idx;
                if (r.idx < q && addr < COIL_DEPTH) coil_mem[addr] = (r.value != 0);
                if (r.last) push_ack();
            end
            mbrts_pkg::MODE_EL_REG: begin
                q = (r.qty > mbrts_pkg::WRITE_REG_MAX) ? mbrts_pkg::WRITE_REG_MAX : r.qty;
                addr = r.start + r.idx;
                if (r.idx < q && addr < REG_DEPTH) hold_mem[addr] = r.value;
                if (r.last) push_ack();
            end
            default: ;
        endcase
    endfunction

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic send_req(input mb_req_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {2'b00, r.value, r.idx, r.qty, r.start};
        s_tlast  <= r.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        serve_request(r);
        reqs_sent++;
    endtask

    // Drop valid for a random gap once the current burst runs out
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 15);
        end
    endtask

    // Pause the sender until every response is in, then let the block settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_req(make_req(mbrts_pkg::MODE_RD_COIL, 0, 0, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_REG, 0, 0, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_REG, 0, 0, 0, 16'hFFFF, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_REG, 127, 0, 0, 16'hA5A5, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_REG, 128, 0, 0, 16'h1234, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_REG, 65535, 2047, 2047, 16'hFFFF, 1));
        send_req(make_req(mbrts_pkg::MODE_WR_COIL, 0, 0, 0, 1, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_COIL, 255, 0, 0, 16'h8000, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_COIL, 256, 0, 0, 1, 0));
        send_req(make_req(mbrts_pkg::MODE_WR_COIL, 65535, 0, 0, 16'hFFFF, 0));
        // multiple register write running off the top of the store
        send_req(make_req(mbrts_pkg::MODE_EL_REG, 126, 3, 0, 16'h0001, 0));
        send_req(make_req(mbrts_pkg::MODE_EL_REG, 126, 3, 1, 16'h8000, 0));
        send_req(make_req(mbrts_pkg::MODE_EL_REG, 126, 3, 2, 16'h7FFF, 1));
        // element beyond its quantity, then a clamped quantity
        send_req(make_req(mbrts_pkg::MODE_EL_REG, 10, 2, 5, 16'hDEAD, 0));
        send_req(make_req(mbrts_pkg::MODE_EL_REG, 0, 2047, 2047, 16'hBEEF, 1));
        send_req(make_req(mbrts_pkg::MODE_EL_COIL, 254, 2047, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_EL_COIL, 254, 2047, 1, 16'h0100, 0));
        send_req(make_req(mbrts_pkg::MODE_EL_COIL, 254, 2047, 2, 1, 1));
        send_req(make_req(MODE_RSVD6, 0, 1, 0, 1, 1));
        send_req(make_req(MODE_RSVD7, 65535, 2047, 2047, 16'hFFFF, 1));
        send_req(make_req(mbrts_pkg::MODE_RD_REG, 0, 125, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_REG, 126, 2047, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_REG, 65535, 3, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_COIL, 250, 13, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_COIL, 65535, 1, 0, 0, 0));
        send_req(make_req(mbrts_pkg::MODE_RD_COIL, 0, 2047, 0, 0, 0));
        wait_drain();
    endtask

    function automatic int unsigned pick_addr(input int unsigned depth);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return $urandom_range(0, depth - 1);
        if (sel < 17) return $urandom_range(depth - 8, depth + 8);
        return $urandom_range(0, 65535);
    endfunction

    // One multiple write, occasionally malformed
    task automatic send_multi_write(input logic [2:0] kind);
        int unsigned q, n, k, start, idx, depth;
        bit          broken, last;
        depth = (kind == mbrts_pkg::MODE_EL_COIL) ? COIL_DEPTH : REG_DEPTH;
        q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 10);
        n = (q > 12) ? $urandom_range(1, 12) : q;
        if (n == 0) n = 1;
        start = pick_addr(depth);
        broken = ($urandom_range(0, 7) == 0);
        for (k = 0; k < n; k++) begin
            idx = k;
            last = (k == n - 1);
            if (broken && last) begin
                idx = $urandom_range(0, 2047);
                last = 1'($urandom_range(0, 1));
            end
            pace_sender();
            send_req(make_req(kind, start, q, idx, $urandom(), last));
        end
    endtask

    task automatic test_random_traffic();
        int unsigned sel, base, q;
        base = reqs_sent;
        while (reqs_sent - base < RANDOM_REQS) begin
            sel = $urandom_range(0, 99);
            if (sel < 18) begin
                pace_sender();
                send_req(make_req(mbrts_pkg::MODE_WR_REG, pick_addr(REG_DEPTH), $urandom(),
                                  $urandom(), $urandom(), 1'($urandom())));
            end else if (sel < 33) begin
                pace_sender();
                send_req(make_req(mbrts_pkg::MODE_WR_COIL, pick_addr(COIL_DEPTH), $urandom(),
                                  $urandom(), ($urandom_range(0, 1) ? $urandom() : 0),
                                  1'($urandom())));
            end else if (sel < 53) begin
                send_multi_write(($urandom_range(0, 1)) ? mbrts_pkg::MODE_EL_COIL
                                                        : mbrts_pkg::MODE_EL_REG);
            end else if (sel < 73) begin
                q = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 2047)
                                                 : $urandom_range(0, 16);
                pace_sender();
                send_req(make_req(mbrts_pkg::MODE_RD_REG, pick_addr(REG_DEPTH), q, $urandom(),
                                  $urandom(), 1'($urandom())));
            end else if (sel < 95) begin
                q = ($urandom_range(0, 24) == 0) ? $urandom_range(1000, 2047)
                                                 : $urandom_range(0, 150);
                pace_sender();
                send_req(make_req(mbrts_pkg::MODE_RD_COIL, pick_addr(COIL_DEPTH), q,
                                  $urandom(), $urandom(), 1'($urandom())));
            end else begin
                // noise: any mode, any field
                pace_sender();
                send_req(make_req(3'($urandom()), $urandom(), $urandom(), $urandom(),
                                  $urandom(), 1'($urandom())));
            end
        end
        wait_drain();
    endtask

    // Stall the result side for a long stretch while requests keep coming
    task automatic test_backpressure_fill();
        int k;
        hold_off_req = 1'b1;
        for (k = 0; k < 30; k++) begin
            if (k % 3 == 0)
                send_req(make_req(mbrts_pkg::MODE_RD_REG, $urandom_range(0, 127),
                                  $urandom_range(1, 8), 0, 0, 0));
            else if (k % 3 == 1)
                send_req(make_req(mbrts_pkg::MODE_WR_REG, $urandom_range(0, 127), 0, 0,
                                  $urandom(), 0));
            else
                send_req(make_req(mbrts_pkg::MODE_RD_COIL, $urandom_range(0, 255),
                                  $urandom_range(1, 70), 0, 0, 0));
        end
        wait_drain();
    endtask

    // Result side: long hold-off on request, otherwise a rotating stall pattern
    initial begin : rx_side
        int unsigned k, rx_cycle;
        rx_cycle = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (rx_cycle % 4 != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                rx_cycle++;
            end
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge aclk) begin
        mb_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp.size() == 0) begin
                $error("unexpected response: tdata %h tlast %b", m_tdata, m_tlast);
                error_count++;
            end else begin
                want = pending_resp.pop_front();
                if (m_tdata[7:0] !== want.byte_count) begin
                    $error("byte_count mismatch: expected %0d, got %0d",
                           want.byte_count, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[16:8] !== want.frame_bytes) begin
                    $error("frame_bytes mismatch: expected %0d, got %0d",
                           want.frame_bytes, m_tdata[16:8]);
                    error_count++;
                end
                if (m_tdata[80:17] !== want.data_chunk) begin
                    $error("data_chunk mismatch: expected %h, got %h",
                           want.data_chunk, m_tdata[80:17]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_result mismatch: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin : main_seq
        int i;
        for (i = 0; i < REG_DEPTH; i++) hold_mem[i] = '0;
        for (i = 0; i < COIL_DEPTH; i++) coil_mem[i] = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure_fill();
        test_random_traffic();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
